@@ design/sfr_pkg.sv @@
// Shared constants for the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int LEN_W = 4;

   localparam int MAX_PATTERN_DEFAULT = 8;
   localparam int MAX_REPLACEMENT_DEFAULT = 8;

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
   localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
   localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

endpackage
`default_nettype wire

@@ design/sfr_req_if.sv @@
// Input byte channel of the stream find-and-replace block.
`default_nettype none
interface sfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  in_byte;
   logic                        in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

@@ design/sfr_rsp_if.sv @@
// Result byte channel of the stream find-and-replace block.
`default_nettype none
interface sfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  out_byte;
   logic                        out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

@@ design/stream_find_and_replace.sv @@
// Streaming find-and-replace: pending-byte window, parallel compare, result buffer.
// The first result word of an input word is offered in the cycle after it is accepted.
// Throughput: one input word per cycle while each word yields at most one result and the
// output is not stalled; a word that yields more results holds off the next input until
// the single result buffer has drained, one word a cycle while the output is ready.
// Reset (synchronous): empties window and buffer, zeroes byte registers, lengths to one.
`default_nettype none
module stream_find_and_replace #(
   parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEFAULT,
   parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sfr_req_if.sink                              req_chan,
   sfr_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int OB  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
   localparam int OBW = sfr_pkg::BYTE_W * OB;
   localparam int CW  = $clog2(MAX_PATTERN + 1);
   localparam int RCW = $clog2(MAX_REPLACEMENT + 1);
   localparam int OCW = $clog2(OB + 1);

   // Registers.
   logic [sfr_pkg::CSR_DATA_W-1:0] pattern_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]      pattern_length_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] replacement_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]      replacement_length_ff;

   logic [OBW-1:0] window_ff,     window_in;
   logic [CW-1:0]  window_cnt_ff, window_cnt_in;
   logic [OBW-1:0] obuf_ff,       obuf_in;
   logic [OCW-1:0] obuf_cnt_ff,   obuf_cnt_in;
   logic           obuf_last_ff,  obuf_last_in;

   logic           csr_write;
   logic [1:0]     csr_index;
   logic           accept;
   logic           pop;

   logic [CW-1:0]  plen;
   logic [RCW-1:0] rlen;
   logic [OBW-1:0] appended;
   logic [OBW-1:0] repl_ext;
   logic [CW-1:0]  cnt;
   logic [CW-1:0]  drop;
   logic [CW-1:0]  emit_cnt;
   logic           match;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         sfr_pkg::REG_PATTERN_BYTES:      csr_prdata = pattern_bytes_ff;
         sfr_pkg::REG_PATTERN_LENGTH:     csr_prdata = 64'(pattern_length_ff);
         sfr_pkg::REG_REPLACEMENT_BYTES:  csr_prdata = replacement_bytes_ff;
         sfr_pkg::REG_REPLACEMENT_LENGTH: csr_prdata = 64'(replacement_length_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= 4'd1;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= 4'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_ff      <= csr_pwdata;
            sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_ff     <= csr_pwdata[3:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_pwdata;
            sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one; a length above the maximum saturates.
   always_comb begin
      if (pattern_length_ff == '0) begin
         plen = CW'(1);
      end else if (pattern_length_ff > 4'(MAX_PATTERN)) begin
         plen = CW'(MAX_PATTERN);
      end else begin
         plen = CW'(pattern_length_ff);
      end
      if (replacement_length_ff == '0) begin
         rlen = RCW'(1);
      end else if (replacement_length_ff > 4'(MAX_REPLACEMENT)) begin
         rlen = RCW'(MAX_REPLACEMENT);
      end else begin
         rlen = RCW'(replacement_length_ff);
      end
   end

   // Handshakes. The buffer may refill in the cycle its final word leaves.
   assign rsp_chan.valid    = (obuf_cnt_ff != '0);
   assign rsp_chan.out_byte = obuf_ff[sfr_pkg::BYTE_W-1:0];
   assign rsp_chan.out_last = obuf_last_ff && (obuf_cnt_ff == OCW'(1));
   assign pop               = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready    = (obuf_cnt_ff == '0) || ((obuf_cnt_ff == OCW'(1)) && rsp_chan.ready);
   assign accept            = req_chan.valid && req_chan.ready;

   // Window update and result selection for the incoming word.
   always_comb begin
      for (int i = 0; i < OB; i++) begin
         appended[8*i +: 8] = (i == int'(window_cnt_ff)) ? req_chan.in_byte
                                                         : window_ff[8*i +: 8];
         repl_ext[8*i +: 8] = (i < MAX_REPLACEMENT) ? replacement_bytes_ff[8*i +: 8] : 8'h00;
      end
      cnt = window_cnt_ff + CW'(1);

      // Only a full window is compared; bytes past the count never take part.
      match = (cnt == plen);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((i < int'(plen)) && (appended[8*i +: 8] != pattern_bytes_ff[8*i +: 8])) begin
            match = 1'b0;
         end
      end

      // Bytes that leave the window unchanged: enough to get back below the pattern
      // length, and the whole window on the final word.
      if (cnt > plen) begin
         drop = cnt - plen + CW'(1);
      end else if (cnt == plen) begin
         drop = CW'(1);
      end else begin
         drop = '0;
      end
      emit_cnt = req_chan.in_last ? cnt : drop;

      if (match || req_chan.in_last) begin
         window_cnt_in = '0;
      end else begin
         window_cnt_in = cnt - drop;
      end
      window_in = appended >> {drop, 3'b000};

      if (accept) begin
         obuf_in      = match ? repl_ext : appended;
         obuf_cnt_in  = match ? OCW'(rlen) : OCW'(emit_cnt);
         obuf_last_in = req_chan.in_last;
      end else begin
         obuf_in      = obuf_ff >> sfr_pkg::BYTE_W;
         obuf_cnt_in  = pop ? (obuf_cnt_ff - OCW'(1)) : obuf_cnt_ff;
         obuf_last_in = obuf_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_cnt_ff <= '0;
         obuf_cnt_ff   <= '0;
      end else begin
         if (accept) begin
            window_cnt_ff <= window_cnt_in;
         end
         obuf_cnt_ff <= obuf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      if (accept || pop) begin
         obuf_ff <= obuf_in;
      end
      obuf_last_ff <= obuf_last_in;
   end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the stream find-and-replace block: random traffic, CSR phases.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [sfr_pkg::BYTE_W-1:0] data;
      logic                       eos;
   } stream_word_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sfr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();

   stream_find_and_replace uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the registers and the pending-byte window.
   logic [63:0]                pat_bytes;
   logic [sfr_pkg::LEN_W-1:0]  pat_len;
   logic [63:0]                rep_bytes;
   logic [sfr_pkg::LEN_W-1:0]  rep_len;
   logic [sfr_pkg::BYTE_W-1:0] win [8];
   int unsigned                win_count;

   stream_word_type text_q [$];
   stream_word_type rewritten_q [$];
   int unsigned     words_queued;
   int unsigned     words_accepted;
   int unsigned     random_words;
   int unsigned     send_gap;
   int unsigned     sink_hold;
   int unsigned     errors;
   bit              calm_phase;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned eff_len(input logic [sfr_pkg::LEN_W-1:0] v,
                                           input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [sfr_pkg::BYTE_W-1:0] window_pop();
      logic [sfr_pkg::BYTE_W-1:0] b;
      int i;
      b = win[0];
      for (i = 0; i < 7; i++) win[i] = win[i + 1];
      if (win_count > 0) win_count--;
      return b;
   endfunction

   // Works out the rewritten words caused by one accepted input word.
   function automatic void rewrite_word(input logic [sfr_pkg::BYTE_W-1:0] b, input logic eos);
      int unsigned                plen;
      int unsigned                rlen;
      int unsigned                n;
      int unsigned                i;
      logic [sfr_pkg::BYTE_W-1:0] outs [16];
      bit                         hit;
      stream_word_type            w;
      plen = eff_len(pat_len, sfr_pkg::MAX_PATTERN_DEFAULT);
      rlen = eff_len(rep_len, sfr_pkg::MAX_REPLACEMENT_DEFAULT);
      n = 0;
      if (win_count > 7) win_count = 7;
      win[win_count] = b;
      win_count++;
      if (win_count > plen) begin
         // The pattern got shorter while bytes were pending: drain without matching.
         while (win_count > plen - 1) begin
            outs[n] = window_pop();
            n++;
         end
      end else if (win_count == plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++) begin
            if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < rlen; i++) begin
               outs[n] = rep_bytes[8*i +: 8];
               n++;
            end
            win_count = 0;
         end else begin
            outs[n] = window_pop();
            n++;
         end
      end
      if (eos) begin
         while (win_count > 0) begin
            outs[n] = window_pop();
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         w.data = outs[i];
         w.eos = eos && (i == n - 1);
         rewritten_q.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : text_driver
      stream_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            rewrite_word(req_if.in_byte, req_if.in_last);
            words_accepted++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (text_q.size() > 0) begin
               w = text_q.pop_front();
               req_if.in_byte <= w.data;
               req_if.in_last <= w.eos;
               req_if.valid <= 1'b1;
               send_gap = pick_gap(calm_phase);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rewritten_monitor
      stream_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (rewritten_q.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                        $time, rsp_if.out_byte, rsp_if.out_last);
               errors++;
            end else begin
               want = rewritten_q.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                           $time, want.data, rsp_if.out_byte);
                  errors++;
               end
               if (rsp_if.out_last !== want.eos) begin
                  $display("%0t: out_last mismatch: expected %0b, actual %0b",
                           $time, want.eos, rsp_if.out_last);
                  errors++;
               end
            end
            sink_hold = pick_gap(calm_phase);
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_word(input logic [sfr_pkg::BYTE_W-1:0] b, input logic eos);
      stream_word_type w;
      w.data = b;
      w.eos = eos;
      text_q.push_back(w);
      words_queued++;
   endtask

   // Idle means every queued word was taken and every rewritten word came back.
   task automatic wait_idle();
      while (!(words_accepted == words_queued && rewritten_q.size() == 0)) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         sfr_pkg::REG_PATTERN_BYTES: pat_bytes = value;
         sfr_pkg::REG_PATTERN_LENGTH: pat_len = value[sfr_pkg::LEN_W-1:0];
         sfr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = value;
         sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = value[sfr_pkg::LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] pb, input logic [3:0] pl,
                            input logic [63:0] rb, input logic [3:0] rl);
      wait_idle();
      csr_write(sfr_pkg::REG_PATTERN_BYTES, pb);
      csr_write(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, pl});
      csr_write(sfr_pkg::REG_REPLACEMENT_BYTES, rb);
      csr_write(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rl});
   endtask

   function automatic logic [3:0] pick_raw_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 4'd0;
      if (r == 1) return 4'($urandom_range(9, 15));
      if (r < 4) return 4'd1;
      if (r < 6) return 4'd8;
      return 4'($urandom_range(1, 8));
   endfunction

   // One configuration, then a few streams built mostly from whole and partial patterns.
   task automatic random_phase();
      logic [sfr_pkg::BYTE_W-1:0] alpha [3];
      logic [sfr_pkg::BYTE_W-1:0] text [$];
      logic [63:0]                pb;
      logic [3:0]                 pl;
      int unsigned                plen;
      int unsigned                streams;
      int unsigned                target;
      int unsigned                k;
      int unsigned                r;
      int unsigned                i;
      int unsigned                s;
      bit                         close;
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < 8; i++) begin
         if ($urandom_range(0, 9) < 7) pb[8*i +: 8] = alpha[$urandom_range(0, 2)];
         else pb[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      pl = pick_raw_len();
      configure(pb, pl, {$urandom, $urandom}, pick_raw_len());
      plen = eff_len(pl, sfr_pkg::MAX_PATTERN_DEFAULT);
      calm_phase = ($urandom_range(0, 4) == 0);
      streams = $urandom_range(1, 4);
      for (s = 0; s < streams; s++) begin
         text.delete();
         target = $urandom_range(1, 24);
         while (text.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 35) k = plen;
            else if (r < 50 && plen > 1) k = $urandom_range(1, plen - 1);
            else k = 0;
            if (k > 0) begin
               for (i = 0; i < k; i++) text.push_back(pat_bytes[8*i +: 8]);
            end else if (r < 80) begin
               text.push_back(alpha[$urandom_range(0, 2)]);
            end else begin
               text.push_back(8'($urandom_range(0, 255)));
            end
         end
         close = ($urandom_range(0, 99) < 85);
         for (i = 0; i < text.size(); i++) queue_word(text[i], close && (i == text.size() - 1));
         random_words += text.size();
      end
   endtask

   initial begin : stimulus
      int i;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_byte = '0;
      req_if.in_last = 1'b0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      pat_bytes = '0;
      pat_len = 4'd1;
      rep_bytes = '0;
      rep_len = 4'd1;
      win_count = 0;
      words_queued = 0;
      words_accepted = 0;
      random_words = 0;
      errors = 0;
      calm_phase = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a single zero byte is replaced by itself.
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b1);

      // "ab" becomes "XYZ"; the search restarts after each replacement.
      configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      queue_word(8'h78, 1'b0);
      for (i = 0; i < 3; i++) begin
         queue_word(8'h61, 1'b0);
         queue_word(8'h62, i == 2);
      end

      // Longest pattern and replacement, then leave five bytes pending.
      configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd8);
      for (i = 0; i < 13; i++) queue_word(8'hFF, 1'b0);

      // Zero pattern length acts as one, which drains the pending bytes unmatched;
      // an oversized replacement length saturates.
      configure(64'h0000_0000_0000_00FF, 4'd0, 64'h8877_6655_4433_2211, 4'd15);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b1);

      // Oversized pattern length, zero replacement length, a lone final word.
      configure(64'h5555_5555_5555_5555, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0);
      queue_word(8'h80, 1'b1);

      while (random_words < 350) random_phase();

      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/sfr_pkg.sv
design/sfr_req_if.sv
design/sfr_rsp_if.sv
design/stream_find_and_replace.sv
dv/tb.sv
